// ----- hw/rtl/cpualu_pkg.sv -----
// ----------------------------------------------------------------------------
// cpualu_pkg: shared definitions for the CPU ALU and register execute block
// Field widths, flag positions, opcode constants, register codes and the
// opcode class decoder used by the execute datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpualu_pkg;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned FLAG_W  = 4;
    localparam int unsigned PIDX_W  = 3;

    // Packed stream widths (data widths padded to whole bytes)
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 88;
    localparam int unsigned OUT_USER_W = 2;

    // Flag bit positions inside the four-bit flag word
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    // Single opcodes with their own behavior
    localparam logic [7:0] OP_DAA    = 8'h27;
    localparam logic [7:0] OP_CPL    = 8'h2F;
    localparam logic [7:0] OP_SCF    = 8'h37;
    localparam logic [7:0] OP_CCF    = 8'h3F;
    localparam logic [7:0] OP_ADD_SP = 8'hE8;

    // Low opcode bits that select a group inside the first quarter (LO3_IMM: the last quarter)
    localparam logic [2:0] LO3_INC8  = 3'd4;
    localparam logic [2:0] LO3_DEC8  = 3'd5;
    localparam logic [2:0] LO3_IMM   = 3'd6;
    localparam logic [3:0] LO4_INC16 = 4'h3;
    localparam logic [3:0] LO4_DEC16 = 4'hB;
    localparam logic [3:0] LO4_ADDHL = 4'h9;

    // Eight-bit register codes as encoded in opcode fields
    localparam logic [2:0] R8_B    = 3'd0;
    localparam logic [2:0] R8_C    = 3'd1;
    localparam logic [2:0] R8_D    = 3'd2;
    localparam logic [2:0] R8_E    = 3'd3;
    localparam logic [2:0] R8_H    = 3'd4;
    localparam logic [2:0] R8_L    = 3'd5;
    localparam logic [2:0] R8_MEM  = 3'd6;
    localparam logic [2:0] R8_A    = 3'd7;

    // Register pair codes
    localparam logic [2:0] PAIR_BC = 3'd0;
    localparam logic [2:0] PAIR_DE = 3'd1;
    localparam logic [2:0] PAIR_HL = 3'd2;
    localparam logic [2:0] PAIR_SP = 3'd3;
    localparam logic [2:0] PAIR_AF = 3'd4;

    // Decimal adjust constants
    localparam logic [7:0] DAA_LIMIT  = 8'h99;
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [3:0] DAA_DIGIT  = 4'h9;

    // Request kinds
    localparam logic REQ_EXEC    = 1'b0;
    localparam logic REQ_PAIR_WR = 1'b1;

    // Eight-bit ALU operations (opcode bits 5..3)
    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_ADC = 3'd1,
        ALU_SUB = 3'd2,
        ALU_SBC = 3'd3,
        ALU_AND = 3'd4,
        ALU_XOR = 3'd5,
        ALU_OR  = 3'd6,
        ALU_CP  = 3'd7
    } t_alu_op;

    // Instruction classes
    typedef enum logic [3:0] {
        CLS_NONE,
        CLS_PAIR_WR,
        CLS_ALU,
        CLS_INCDEC8,
        CLS_INC16,
        CLS_DEC16,
        CLS_ADD_HL,
        CLS_ADD_SP,
        CLS_DAA,
        CLS_CPL,
        CLS_SCF,
        CLS_CCF
    } t_op_class;

    // Decode one request into its class, in priority order.
    function automatic t_op_class decode_class(input logic req, input logic [7:0] op);
        t_op_class cls;
        cls = CLS_NONE;
        if (req == REQ_PAIR_WR) begin
            cls = CLS_PAIR_WR;
        end else if (op inside {[8'h80:8'hBF]}) begin
            cls = CLS_ALU;
        end else if (op[7:6] == 2'b11 && op[2:0] == LO3_IMM) begin
            cls = CLS_ALU;
        end else if (op[7:6] == 2'b00 && (op[2:0] == LO3_INC8 || op[2:0] == LO3_DEC8)) begin
            cls = CLS_INCDEC8;
        end else if (op[7:6] == 2'b00 && op[3:0] == LO4_INC16) begin
            cls = CLS_INC16;
        end else if (op[7:6] == 2'b00 && op[3:0] == LO4_DEC16) begin
            cls = CLS_DEC16;
        end else if (op[7:6] == 2'b00 && op[3:0] == LO4_ADDHL) begin
            cls = CLS_ADD_HL;
        end else if (op == OP_ADD_SP) begin
            cls = CLS_ADD_SP;
        end else if (op == OP_DAA) begin
            cls = CLS_DAA;
        end else if (op == OP_CPL) begin
            cls = CLS_CPL;
        end else if (op == OP_SCF) begin
            cls = CLS_SCF;
        end else if (op == OP_CCF) begin
            cls = CLS_CCF;
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cpu_alu_register_execute.sv -----
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle unless the output stalls; the register file is updated in the
// same cycle the result register loads, so the next item reads the updated state without waiting.
// The single stage between input and result register holds all decode and arithmetic.
// Reset (i_rst_n low, synchronous) clears A, flags, B..L, SP and both valid flags.
// ----------------------------------------------------------------------------
// cpu_alu_register_execute: CPU ALU execute stage with register file
// Holds A, the Z N H C flags, B, C, D, E, H, L and SP. Executes the eight-bit
// ALU, increment and decrement, sixteen-bit arithmetic, DAA, CPL, SCF and CCF
// opcodes, and takes register pair writes. Each item returns the full
// register file plus any memory write-back for INC (HL) and DEC (HL).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpu_alu_register_execute (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Input stream
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [7:0] opcode, [15:8] mem_byte, [18:16] pair_index, [34:19] pair_value
    input  wire logic [cpualu_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] req_type
    input  wire logic                                  s_axis_tuser,
    // Output stream
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [7:0] acc_out, [11:8] flags_out, [27:12] bc_out, [43:28] de_out,
    // [59:44] hl_out, [75:60] sp_out, [83:76] mem_write_byte
    output logic [cpualu_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    // [0] mem_write, [1] handled
    output logic [cpualu_pkg::OUT_USER_W-1:0]          m_axis_tuser
);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic        r_in_valid;
    logic        r_in_req;
    logic [7:0]  r_in_op;
    logic [7:0]  r_in_mb;
    logic [2:0]  r_in_pidx;
    logic [15:0] r_in_pval;

    // Architectural state
    logic [7:0]  r_a, r_b, r_c, r_d, r_e, r_h, r_l;
    logic [3:0]  r_f;
    logic [15:0] r_sp;
    logic [7:0]  n_a, n_b, n_c, n_d, n_e, n_h, n_l;
    logic [3:0]  n_f;
    logic [15:0] n_sp;

    // Result register
    logic        r_out_valid;
    logic [7:0]  r_out_acc;
    logic [3:0]  r_out_flags;
    logic [15:0] r_out_bc, r_out_de, r_out_hl, r_out_sp;
    logic        r_out_mem_wr;
    logic [7:0]  r_out_wbyte;
    logic        r_out_handled;

    // Stage results
    logic        n_mem_wr;
    logic [7:0]  n_wbyte;
    logic        n_handled;

    logic        advance;
    cpualu_pkg::t_op_class op_class;
    logic [7:0]  src8;
    logic [7:0]  dst8;
    logic [15:0] pair16;

    // Move the input stage forward when the result register is free or drains.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Input payload capture on every transfer.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_req  <= s_axis_tuser;
            r_in_op   <= s_axis_tdata[7:0];
            r_in_mb   <= s_axis_tdata[15:8];
            r_in_pidx <= s_axis_tdata[18:16];
            r_in_pval <= s_axis_tdata[34:19];
        end
    end

    assign op_class = cpualu_pkg::decode_class(r_in_req, r_in_op);

    // Source operand of the eight-bit ALU group (opcode bits 2..0).
    always_comb begin
        case (r_in_op[2:0])
            cpualu_pkg::R8_B:   src8 = r_b;
            cpualu_pkg::R8_C:   src8 = r_c;
            cpualu_pkg::R8_D:   src8 = r_d;
            cpualu_pkg::R8_E:   src8 = r_e;
            cpualu_pkg::R8_H:   src8 = r_h;
            cpualu_pkg::R8_L:   src8 = r_l;
            cpualu_pkg::R8_MEM: src8 = r_in_mb;
            default:            src8 = r_a;
        endcase
    end

    // Target operand of INC and DEC (opcode bits 5..3).
    always_comb begin
        case (r_in_op[5:3])
            cpualu_pkg::R8_B:   dst8 = r_b;
            cpualu_pkg::R8_C:   dst8 = r_c;
            cpualu_pkg::R8_D:   dst8 = r_d;
            cpualu_pkg::R8_E:   dst8 = r_e;
            cpualu_pkg::R8_H:   dst8 = r_h;
            cpualu_pkg::R8_L:   dst8 = r_l;
            cpualu_pkg::R8_MEM: dst8 = r_in_mb;
            default:            dst8 = r_a;
        endcase
    end

    // Register pair selected by opcode bits 5..4.
    always_comb begin
        case ({1'b0, r_in_op[5:4]})
            cpualu_pkg::PAIR_BC: pair16 = {r_b, r_c};
            cpualu_pkg::PAIR_DE: pair16 = {r_d, r_e};
            cpualu_pkg::PAIR_HL: pair16 = {r_h, r_l};
            default:             pair16 = r_sp;
        endcase
    end

    // Execute: next register file, flags and memory write-back.
    always_comb begin
        logic [8:0]  alu9;
        logic [4:0]  nib5;
        logic        cin;
        logic [7:0]  res8;
        logic [7:0]  daa8;
        logic        daa_c;
        logic [15:0] res16;
        logic [16:0] hl17;
        logic [12:0] hl13;
        logic [8:0]  sp9;
        logic [4:0]  sp5;
        logic [3:0]  f;

        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d;
        n_e = r_e; n_h = r_h; n_l = r_l;
        n_f = r_f; n_sp = r_sp;
        n_mem_wr  = 1'b0;
        n_wbyte   = '0;
        n_handled = 1'b1;
        alu9 = '0; nib5 = '0; cin = 1'b0; res8 = '0; daa8 = '0; daa_c = 1'b0;
        res16 = '0; hl17 = '0; hl13 = '0; sp9 = '0; sp5 = '0; f = '0;

        case (op_class)
            cpualu_pkg::CLS_PAIR_WR: begin
                n_handled = 1'b0;
                case (r_in_pidx)
                    cpualu_pkg::PAIR_BC: begin
                        n_b = r_in_pval[15:8]; n_c = r_in_pval[7:0];
                    end
                    cpualu_pkg::PAIR_DE: begin
                        n_d = r_in_pval[15:8]; n_e = r_in_pval[7:0];
                    end
                    cpualu_pkg::PAIR_HL: begin
                        n_h = r_in_pval[15:8]; n_l = r_in_pval[7:0];
                    end
                    cpualu_pkg::PAIR_SP: n_sp = r_in_pval;
                    cpualu_pkg::PAIR_AF: begin
                        n_a = r_in_pval[15:8]; n_f = r_in_pval[7:4];
                    end
                    default: ;
                endcase
            end

            cpualu_pkg::CLS_ALU: begin
                case (cpualu_pkg::t_alu_op'(r_in_op[5:3]))
                    cpualu_pkg::ALU_ADD, cpualu_pkg::ALU_ADC: begin
                        cin  = (r_in_op[5:3] == 3'(cpualu_pkg::ALU_ADC)) && r_f[cpualu_pkg::FLAG_C];
                        alu9 = {1'b0, r_a} + {1'b0, src8} + {8'b0, cin};
                        nib5 = {1'b0, r_a[3:0]} + {1'b0, src8[3:0]} + {4'b0, cin};
                        res8 = alu9[7:0];
                        f[cpualu_pkg::FLAG_H] = nib5[4];
                        f[cpualu_pkg::FLAG_C] = alu9[8];
                    end
                    cpualu_pkg::ALU_SUB, cpualu_pkg::ALU_SBC, cpualu_pkg::ALU_CP: begin
                        cin  = (r_in_op[5:3] == 3'(cpualu_pkg::ALU_SBC)) && r_f[cpualu_pkg::FLAG_C];
                        alu9 = {1'b0, r_a} - {1'b0, src8} - {8'b0, cin};
                        nib5 = {1'b0, r_a[3:0]} - {1'b0, src8[3:0]} - {4'b0, cin};
                        res8 = alu9[7:0];
                        f[cpualu_pkg::FLAG_N] = 1'b1;
                        f[cpualu_pkg::FLAG_H] = nib5[4];
                        f[cpualu_pkg::FLAG_C] = alu9[8];
                    end
                    cpualu_pkg::ALU_AND: begin
                        res8 = r_a & src8;
                        f[cpualu_pkg::FLAG_H] = 1'b1;
                    end
                    cpualu_pkg::ALU_XOR: res8 = r_a ^ src8;
                    default:             res8 = r_a | src8;
                endcase
                f[cpualu_pkg::FLAG_Z] = (res8 == 8'h00);
                n_f = f;
                if (r_in_op[5:3] != 3'(cpualu_pkg::ALU_CP)) begin
                    n_a = res8;
                end
            end

            cpualu_pkg::CLS_INCDEC8: begin
                f[cpualu_pkg::FLAG_C] = r_f[cpualu_pkg::FLAG_C];
                if (r_in_op[2:0] == cpualu_pkg::LO3_INC8) begin
                    res8 = dst8 + 8'd1;
                    f[cpualu_pkg::FLAG_H] = (dst8[3:0] == 4'hF);
                end else begin
                    res8 = dst8 - 8'd1;
                    f[cpualu_pkg::FLAG_N] = 1'b1;
                    f[cpualu_pkg::FLAG_H] = (dst8[3:0] == 4'h0);
                end
                f[cpualu_pkg::FLAG_Z] = (res8 == 8'h00);
                n_f = f;
                case (r_in_op[5:3])
                    cpualu_pkg::R8_B:   n_b = res8;
                    cpualu_pkg::R8_C:   n_c = res8;
                    cpualu_pkg::R8_D:   n_d = res8;
                    cpualu_pkg::R8_E:   n_e = res8;
                    cpualu_pkg::R8_H:   n_h = res8;
                    cpualu_pkg::R8_L:   n_l = res8;
                    cpualu_pkg::R8_MEM: begin
                        n_mem_wr = 1'b1;
                        n_wbyte  = res8;
                    end
                    default:            n_a = res8;
                endcase
            end

            cpualu_pkg::CLS_INC16, cpualu_pkg::CLS_DEC16: begin
                if (op_class == cpualu_pkg::CLS_INC16) begin
                    res16 = pair16 + 16'd1;
                end else begin
                    res16 = pair16 - 16'd1;
                end
                case ({1'b0, r_in_op[5:4]})
                    cpualu_pkg::PAIR_BC: begin n_b = res16[15:8]; n_c = res16[7:0]; end
                    cpualu_pkg::PAIR_DE: begin n_d = res16[15:8]; n_e = res16[7:0]; end
                    cpualu_pkg::PAIR_HL: begin n_h = res16[15:8]; n_l = res16[7:0]; end
                    default:             n_sp = res16;
                endcase
            end

            cpualu_pkg::CLS_ADD_HL: begin
                hl17 = {1'b0, r_h, r_l} + {1'b0, pair16};
                hl13 = {1'b0, r_h[3:0], r_l} + {1'b0, pair16[11:0]};
                f[cpualu_pkg::FLAG_Z] = r_f[cpualu_pkg::FLAG_Z];
                f[cpualu_pkg::FLAG_H] = hl13[12];
                f[cpualu_pkg::FLAG_C] = hl17[16];
                n_f = f;
                n_h = hl17[15:8];
                n_l = hl17[7:0];
            end

            cpualu_pkg::CLS_ADD_SP: begin
                // Flags come from the unsigned low-byte add; SP takes the signed offset.
                sp9 = {1'b0, r_sp[7:0]} + {1'b0, r_in_mb};
                sp5 = {1'b0, r_sp[3:0]} + {1'b0, r_in_mb[3:0]};
                f[cpualu_pkg::FLAG_H] = sp5[4];
                f[cpualu_pkg::FLAG_C] = sp9[8];
                n_f  = f;
                n_sp = r_sp + {{8{r_in_mb[7]}}, r_in_mb};
            end

            cpualu_pkg::CLS_DAA: begin
                daa8  = r_a;
                daa_c = r_f[cpualu_pkg::FLAG_C];
                if (!r_f[cpualu_pkg::FLAG_N]) begin
                    if (r_f[cpualu_pkg::FLAG_C] || (r_a > cpualu_pkg::DAA_LIMIT)) begin
                        daa8  = daa8 + cpualu_pkg::DAA_HI_ADJ;
                        daa_c = 1'b1;
                    end
                    if (r_f[cpualu_pkg::FLAG_H] || (daa8[3:0] > cpualu_pkg::DAA_DIGIT)) begin
                        daa8 = daa8 + cpualu_pkg::DAA_LO_ADJ;
                    end
                end else begin
                    if (r_f[cpualu_pkg::FLAG_C]) begin
                        daa8 = daa8 - cpualu_pkg::DAA_HI_ADJ;
                    end
                    if (r_f[cpualu_pkg::FLAG_H]) begin
                        daa8 = daa8 - cpualu_pkg::DAA_LO_ADJ;
                    end
                end
                f[cpualu_pkg::FLAG_Z] = (daa8 == 8'h00);
                f[cpualu_pkg::FLAG_N] = r_f[cpualu_pkg::FLAG_N];
                f[cpualu_pkg::FLAG_C] = daa_c;
                n_f = f;
                n_a = daa8;
            end

            cpualu_pkg::CLS_CPL: begin
                n_a = ~r_a;
                n_f = r_f;
                n_f[cpualu_pkg::FLAG_N] = 1'b1;
                n_f[cpualu_pkg::FLAG_H] = 1'b1;
            end

            cpualu_pkg::CLS_SCF: begin
                f[cpualu_pkg::FLAG_Z] = r_f[cpualu_pkg::FLAG_Z];
                f[cpualu_pkg::FLAG_C] = 1'b1;
                n_f = f;
            end

            cpualu_pkg::CLS_CCF: begin
                f[cpualu_pkg::FLAG_Z] = r_f[cpualu_pkg::FLAG_Z];
                f[cpualu_pkg::FLAG_C] = ~r_f[cpualu_pkg::FLAG_C];
                n_f = f;
            end

            default: n_handled = 1'b0;
        endcase
    end

    // Register file update on each executed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a  <= '0; r_f <= '0;
            r_b  <= '0; r_c <= '0; r_d <= '0; r_e <= '0; r_h <= '0; r_l <= '0;
            r_sp <= '0;
        end else if (advance) begin
            r_a  <= n_a; r_f <= n_f;
            r_b  <= n_b; r_c <= n_c; r_d <= n_d; r_e <= n_e; r_h <= n_h; r_l <= n_l;
            r_sp <= n_sp;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_acc     <= n_a;
            r_out_flags   <= n_f;
            r_out_bc      <= {n_b, n_c};
            r_out_de      <= {n_d, n_e};
            r_out_hl      <= {n_h, n_l};
            r_out_sp      <= n_sp;
            r_out_mem_wr  <= n_mem_wr;
            r_out_wbyte   <= n_wbyte;
            r_out_handled <= n_handled;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_wbyte, r_out_sp, r_out_hl, r_out_de, r_out_bc,
                            r_out_flags, r_out_acc};
    assign m_axis_tuser  = {r_out_handled, r_out_mem_wr};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A memory write-back only comes from an executed INC or DEC (HL).
    a_wr_handled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_mem_wr |-> r_out_handled)
        else $error("memory write-back reported for an unhandled item");

    // The write-back byte is zero whenever no write is reported.
    a_wbyte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_mem_wr |-> r_out_wbyte == 8'h00)
        else $error("write-back byte nonzero without a memory write");

    // The reported A, flags, SP and HL match the architectural state just written.
    a_state_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out_acc == r_a) && (r_out_flags == r_f) && (r_out_sp == r_sp)
                    && (r_out_hl == {r_h, r_l}))
        else $error("result register disagrees with register file");

    // The input side only stalls while an item waits in the input register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CPU ALU and register execute block
// A directed table covers the reset state, field extremes, every operation
// and the decimal adjust paths. It is followed by several hundred random
// transfers. Every result is compared field by field against a typed row's own want, or else
// against a behavioral copy of the register file that lives in this bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import cpualu_pkg::*;

    // Run length, pacing and limits
    localparam int          RANDOM_ITEMS = 670;
    localparam int          HOLD_AT      = 320;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          LIMIT_CYCLES = 200000;
    localparam int          DIR_N        = 30;
    localparam logic [7:0]  OP_NOP       = 8'h00;
    localparam logic [2:0]  PAIR_UNUSED  = 3'd7;

    // One input transfer, split into its fields
    typedef struct packed {
        logic        req;
        logic [7:0]  opcode;
        logic [7:0]  mem_byte;
        logic [2:0]  pidx;
        logic [15:0] pval;
    } exec_item_t;

    // Register file and write-back after one item
    typedef struct packed {
        logic [7:0]  acc;
        logic [3:0]  flags;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic [15:0] sp;
        logic        mem_wr;
        logic [7:0]  mem_byte;
        logic        handled;
    } regfile_t;

    // Directed stimulus row; typed rows carry their own expected register file
    typedef struct packed {
        logic       typed;
        exec_item_t item;
        regfile_t   want;
    } dir_row_t;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [OUT_USER_W-1:0]  m_axis_tuser;

    // Bench copy of the register file
    logic [7:0]  acc_q;
    logic [3:0]  flg_q;
    logic [7:0]  gpr_q [6];
    logic [15:0] sp_q;

    regfile_t    regfile_q [$];
    int          mismatches   = 0;
    int          results_seen = 0;
    int          mem_writes   = 0;
    int          unhandled    = 0;
    int          stall_left   = 0;
    int          cycles       = 0;
    logic        rx_no_stall  = 1'b0;

    dir_row_t dir_rows [DIR_N] = '{
        // Reset state, then extreme values written into the register file
        '{1'b1, '{REQ_EXEC, OP_NOP, 8'h00, PAIR_BC, 16'h0000},
              '{8'h00, 4'h0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0}},
        '{1'b1, '{REQ_PAIR_WR, OP_NOP, 8'h00, PAIR_AF, 16'hFFF0},
              '{8'hFF, 4'hF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0}},
        '{1'b1, '{REQ_EXEC, {2'b00, R8_A, LO3_INC8}, 8'h00, PAIR_BC, 16'h0000},
              '{8'h00, 4'hB, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b1}},
        '{1'b1, '{REQ_PAIR_WR, OP_NOP, 8'h00, PAIR_UNUSED, 16'hFFFF},
              '{8'h00, 4'hB, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0}},
        '{1'b1, '{REQ_PAIR_WR, OP_NOP, 8'h00, PAIR_BC, 16'hFFFF},
              '{8'h00, 4'hB, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0}},
        '{1'b0, '{REQ_PAIR_WR, OP_NOP, 8'h00, PAIR_DE, 16'h8000}, '0},
        '{1'b0, '{REQ_PAIR_WR, OP_NOP, 8'h00, PAIR_HL, 16'h0FFF}, '0},
        '{1'b0, '{REQ_PAIR_WR, OP_NOP, 8'h00, PAIR_SP, 16'hFFFF}, '0},
        // Each eight-bit ALU operation
        '{1'b0, '{REQ_EXEC, {2'b10, ALU_ADD, R8_B}, 8'h00, PAIR_BC, 16'h0000}, '0},
        '{1'b0, '{REQ_EXEC, {2'b10, ALU_ADC, R8_MEM}, 8'hFF, PAIR_BC, 16'h0000}, '0},
        '{1'b0, '{REQ_EXEC, {2'b11, ALU_SUB, LO3_IMM}, 8'h01, PAIR_BC, 16'h0000}, '0},
        '{1'b0, '{REQ_EXEC, {2'b10, ALU_SBC, R8_A}, 8'h00, PAIR_BC, 16'h0000}, '0},
        '{1'b0, '{REQ_EXEC, {2'b11, ALU_AND, LO3_IMM}, 8'h00, PAIR_BC, 16'h0000}, '0},
        '{1'b0, '{REQ_EXEC, {2'b10, ALU_XOR, R8_C}, 8'h00, PAIR_BC, 16'h0000}, '0},
        '{1'b0, '{REQ_EXEC, {2'b10, ALU_OR, R8_MEM}, 8'h80, PAIR_BC, 16'h0000}, '0},
        '{1'b0, '{REQ_EXEC, {2'b11, ALU_CP, LO3_IMM}, 8'hFF, PAIR_BC, 16'h0000}, '0},
        // Memory write-back, eight and sixteen bit steps with wrap
        '{1'b0, '{REQ_EXEC, {2'b00, R8_MEM, LO3_INC8}, 8'hFF, PAIR_BC, 16'h0000}, '0},
        '{1'b0, '{REQ_EXEC, {2'b00, R8_MEM, LO3_DEC8}, 8'h00, PAIR_BC, 16'h0000}, '0},
        '{1'b0, '{REQ_EXEC, {2'b00, R8_D, LO3_DEC8}, 8'h00, PAIR_BC, 16'h0000}, '0},
        '{1'b0, '{REQ_EXEC, {2'b00, PAIR_SP[1:0], LO4_INC16}, 8'h00, PAIR_BC, 16'h0000}, '0},
        '{1'b0, '{REQ_EXEC, {2'b00, PAIR_BC[1:0], LO4_DEC16}, 8'h00, PAIR_BC, 16'h0000}, '0},
        '{1'b0, '{REQ_EXEC, {2'b00, PAIR_BC[1:0], LO4_ADDHL}, 8'h00, PAIR_BC, 16'h0000}, '0},
        '{1'b0, '{REQ_EXEC, OP_ADD_SP, 8'h80, PAIR_BC, 16'h0000}, '0},
        // Decimal adjust on both the add and the subtract path
        '{1'b0, '{REQ_PAIR_WR, OP_NOP, 8'h00, PAIR_AF, 16'h9A00}, '0},
        '{1'b0, '{REQ_EXEC, OP_DAA, 8'h00, PAIR_BC, 16'h0000}, '0},
        '{1'b0, '{REQ_EXEC, OP_CPL, 8'h00, PAIR_BC, 16'h0000}, '0},
        '{1'b0, '{REQ_EXEC, OP_SCF, 8'h00, PAIR_BC, 16'h0000}, '0},
        '{1'b0, '{REQ_EXEC, OP_CCF, 8'h00, PAIR_BC, 16'h0000}, '0},
        '{1'b0, '{REQ_PAIR_WR, OP_NOP, 8'h00, PAIR_AF, 16'h1560}, '0},
        '{1'b0, '{REQ_EXEC, OP_DAA, 8'h00, PAIR_BC, 16'h0000}, '0}
    };

    cpu_alu_register_execute DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Pair access; index three is SP, the others map onto the byte registers.
    function automatic logic [15:0] pair_rd(input logic [2:0] p);
        if (p == PAIR_SP) return sp_q;
        return {gpr_q[2 * p[1:0]], gpr_q[2 * p[1:0] + 1]};
    endfunction

    function automatic void pair_wr(input logic [2:0] p, input logic [15:0] v);
        if (p == PAIR_SP) begin
            sp_q = v;
        end else begin
            gpr_q[2 * p[1:0]]     = v[15:8];
            gpr_q[2 * p[1:0] + 1] = v[7:0];
        end
    endfunction

    // Eight-bit increment or decrement; carry is left alone.
    function automatic logic [7:0] step8(input logic [7:0] v, input logic down);
        logic [7:0] r;
        r = down ? v - 8'd1 : v + 8'd1;
        flg_q[FLAG_N] = down;
        flg_q[FLAG_H] = down ? (v[3:0] == 4'h0) : (v[3:0] == 4'hF);
        flg_q[FLAG_Z] = (r == 8'd0);
        return r;
    endfunction

    // Accumulator operation against one operand byte; compare leaves A alone.
    function automatic void alu8(input t_alu_op op, input logic [7:0] b);
        int unsigned a, bv, c, r;
        logic [3:0]  f;
        a  = acc_q;
        bv = b;
        c  = 0;
        f  = '0;
        case (op)
            ALU_ADD, ALU_ADC: begin
                if (op == ALU_ADC) c = flg_q[FLAG_C];
                r = a + bv + c;
                f[FLAG_H] = ((a & 15) + (bv & 15) + c) > 15;
                f[FLAG_C] = r > 255;
            end
            ALU_SUB, ALU_SBC, ALU_CP: begin
                if (op == ALU_SBC) c = flg_q[FLAG_C];
                r = a - bv - c;
                f[FLAG_N] = 1'b1;
                f[FLAG_H] = (a & 15) < ((bv & 15) + c);
                f[FLAG_C] = a < (bv + c);
            end
            ALU_AND: begin
                r = a & bv;
                f[FLAG_H] = 1'b1;
            end
            ALU_XOR: r = a ^ bv;
            default: r = a | bv;
        endcase
        r = r & 255;
        f[FLAG_Z] = (r == 0);
        flg_q = f;
        if (op != ALU_CP) acc_q = r[7:0];
    endfunction

    // Decimal adjust of A after a BCD add or subtract.
    function automatic void daa_adjust();
        int unsigned a;
        logic [3:0]  f;
        a = acc_q;
        f = '0;
        f[FLAG_N] = flg_q[FLAG_N];
        f[FLAG_C] = flg_q[FLAG_C];
        if (!flg_q[FLAG_N]) begin
            if (flg_q[FLAG_C] || a > DAA_LIMIT) begin
                a = a + DAA_HI_ADJ;
                f[FLAG_C] = 1'b1;
            end
            if (flg_q[FLAG_H] || (a & 15) > DAA_DIGIT) a = a + DAA_LO_ADJ;
        end else begin
            if (flg_q[FLAG_C]) a = a - DAA_HI_ADJ;
            if (flg_q[FLAG_H]) a = a - DAA_LO_ADJ;
        end
        a = a & 255;
        f[FLAG_Z] = (a == 0);
        acc_q = a[7:0];
        flg_q = f;
    endfunction

    // Apply one item to the bench register file and return what follows from it.
    function automatic regfile_t next_regfile(input exec_item_t it);
        regfile_t    res;
        logic [7:0]  op;
        logic [7:0]  src;
        logic [2:0]  rsel;
        logic [2:0]  pp;
        logic [15:0] hl;
        logic [15:0] other;
        logic [16:0] sum;
        logic [3:0]  f;
        op   = it.opcode;
        rsel = op[5:3];
        pp   = {1'b0, op[5:4]};
        res  = '0;
        res.handled = 1'b1;
        if (it.req == REQ_PAIR_WR) begin
            res.handled = 1'b0;
            if (it.pidx == PAIR_AF) begin
                acc_q = it.pval[15:8];
                flg_q = it.pval[7:4];
            end else if (it.pidx < PAIR_AF) begin
                pair_wr(it.pidx, it.pval);
            end
        end else if (op[7:6] == 2'b10) begin
            src = (op[2:0] == R8_MEM) ? it.mem_byte :
                  (op[2:0] == R8_A)   ? acc_q : gpr_q[op[2:0]];
            alu8(t_alu_op'(op[5:3]), src);
        end else if (op[7:6] == 2'b11 && op[2:0] == LO3_IMM) begin
            alu8(t_alu_op'(op[5:3]), it.mem_byte);
        end else if (op[7:6] == 2'b00 && (op[2:0] == LO3_INC8 || op[2:0] == LO3_DEC8)) begin
            if (rsel == R8_MEM) begin
                res.mem_wr   = 1'b1;
                res.mem_byte = step8(it.mem_byte, op[2:0] == LO3_DEC8);
            end else if (rsel == R8_A) begin
                acc_q = step8(acc_q, op[2:0] == LO3_DEC8);
            end else begin
                gpr_q[rsel] = step8(gpr_q[rsel], op[2:0] == LO3_DEC8);
            end
        end else if (op[7:6] == 2'b00 && op[3:0] == LO4_INC16) begin
            pair_wr(pp, pair_rd(pp) + 16'd1);
        end else if (op[7:6] == 2'b00 && op[3:0] == LO4_DEC16) begin
            pair_wr(pp, pair_rd(pp) - 16'd1);
        end else if (op[7:6] == 2'b00 && op[3:0] == LO4_ADDHL) begin
            hl    = pair_rd(PAIR_HL);
            other = pair_rd(pp);
            sum   = {1'b0, hl} + {1'b0, other};
            flg_q[FLAG_N] = 1'b0;
            flg_q[FLAG_H] = ({1'b0, hl[11:0]} + {1'b0, other[11:0]}) > 13'h0FFF;
            flg_q[FLAG_C] = sum[16];
            pair_wr(PAIR_HL, sum[15:0]);
        end else if (op == OP_ADD_SP) begin
            // Flags come from the unsigned low-byte add; the offset is signed.
            f = '0;
            f[FLAG_H] = ({1'b0, sp_q[3:0]} + {1'b0, it.mem_byte[3:0]}) > 5'h0F;
            f[FLAG_C] = ({1'b0, sp_q[7:0]} + {1'b0, it.mem_byte}) > 9'h0FF;
            flg_q = f;
            sp_q  = sp_q + {{8{it.mem_byte[7]}}, it.mem_byte};
        end else if (op == OP_DAA) begin
            daa_adjust();
        end else if (op == OP_CPL) begin
            acc_q = ~acc_q;
            flg_q[FLAG_N] = 1'b1;
            flg_q[FLAG_H] = 1'b1;
        end else if (op == OP_SCF) begin
            flg_q[FLAG_N] = 1'b0;
            flg_q[FLAG_H] = 1'b0;
            flg_q[FLAG_C] = 1'b1;
        end else if (op == OP_CCF) begin
            flg_q[FLAG_N] = 1'b0;
            flg_q[FLAG_H] = 1'b0;
            flg_q[FLAG_C] = ~flg_q[FLAG_C];
        end else begin
            res.handled = 1'b0;
        end
        res.acc   = acc_q;
        res.flags = flg_q;
        res.bc    = pair_rd(PAIR_BC);
        res.de    = pair_rd(PAIR_DE);
        res.hl    = pair_rd(PAIR_HL);
        res.sp    = sp_q;
        return res;
    endfunction

    // Random item: mostly opcodes of the executed group, some pair writes and noise.
    function automatic exec_item_t rand_item();
        exec_item_t it;
        int         pick;
        logic [3:0] lo4 [3];
        logic [7:0] misc [4];
        lo4  = '{LO4_INC16, LO4_DEC16, LO4_ADDHL};
        misc = '{OP_DAA, OP_CPL, OP_SCF, OP_CCF};
        it.req      = REQ_EXEC;
        it.opcode   = $urandom_range(0, 255);
        it.mem_byte = $urandom_range(0, 255);
        it.pidx     = $urandom_range(0, 7);
        it.pval     = ($urandom_range(0, 15) == 0) ? {16{it.mem_byte[0]}} : $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            it.req = REQ_PAIR_WR;
        end else if (pick >= 25) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: it.opcode = {2'b10, 6'($urandom_range(0, 63))};
                4:          it.opcode = {2'b11, 3'($urandom_range(0, 7)), LO3_IMM};
                5, 6:       it.opcode = {2'b00, 3'($urandom_range(0, 7)),
                                         $urandom_range(0, 1) ? LO3_DEC8 : LO3_INC8};
                7:          it.opcode = {2'b00, 2'($urandom_range(0, 3)),
                                         lo4[$urandom_range(0, 2)]};
                8:          it.opcode = OP_ADD_SP;
                default:    it.opcode = misc[$urandom_range(0, 3)];
            endcase
        end
        return it;
    endfunction

    // Offer one item after any idle gap, wait for the transfer, then record its expected result.
    task automatic send_item(input exec_item_t it, input int gap, input logic typed,
                             input regfile_t typed_want, output regfile_t pred);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, it.pval, it.pidx, it.mem_byte, it.opcode};
        s_axis_tuser  <= it.req;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = next_regfile(it);
        regfile_q.push_back(typed ? typed_want : pred);
    endtask

    // Stop offering and wait until every expected result has been received.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (regfile_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Result side: compare each transfer with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        regfile_t got;
        regfile_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.acc      = m_axis_tdata[7:0];
            got.flags    = m_axis_tdata[11:8];
            got.bc       = m_axis_tdata[27:12];
            got.de       = m_axis_tdata[43:28];
            got.hl       = m_axis_tdata[59:44];
            got.sp       = m_axis_tdata[75:60];
            got.mem_byte = m_axis_tdata[83:76];
            got.mem_wr   = m_axis_tuser[0];
            got.handled  = m_axis_tuser[1];
            if (regfile_q.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected, actual %h", $time, got);
            end else begin
                want = regfile_q.pop_front();
                check_field("acc_out", want.acc, got.acc);
                check_field("flags_out", want.flags, got.flags);
                check_field("bc_out", want.bc, got.bc);
                check_field("de_out", want.de, got.de);
                check_field("hl_out", want.hl, got.hl);
                check_field("sp_out", want.sp, got.sp);
                check_field("mem_write", want.mem_wr, got.mem_wr);
                check_field("mem_write_byte", want.mem_byte, got.mem_byte);
                check_field("handled", want.handled, got.handled);
            end
            results_seen++;
            mem_writes += got.mem_wr;
            unhandled  += !got.handled;
            // One long hold-off lets the pipeline fill and push back on the input.
            if (results_seen == HOLD_AT) stall_left = HOLD_CYCLES;
            else stall_left = rx_no_stall ? 0 : $urandom_range(0, 10);
        end
    end

    // Result side ready: counts down the stall drawn for the last transfer.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Stimulus: reset, directed table, random phases, drain.
    initial begin : stimulus
        regfile_t pred;
        int       n;
        int       gap;
        acc_q = '0;
        flg_q = '0;
        sp_q  = '0;
        foreach (gpr_q[i]) gpr_q[i] = '0;
        n       = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].item, $urandom_range(0, 10), dir_rows[i].typed,
                      dir_rows[i].want, pred);
        end
        wait_drained();

        // Random phases: mixed, then receiver without stalls, then sender back to back while
        // the receiver takes its long hold, then mixed around a full drain pause.
        while (n < RANDOM_ITEMS) begin : random_item
            exec_item_t it;
            rx_no_stall = (n >= 100 && n < 250);
            gap = (n >= 250 && n < 400) ? 0 : $urandom_range(0, 10);
            if (n == 500) wait_drained();
            it = rand_item();
            send_item(it, gap, 1'b0, '0, pred);
            n++;
        end
        rx_no_stall = 1'b0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Ran %0d directed and %0d random transfers; %0d results checked,",
                 DIR_N, n, results_seen);
        $display("including %0d memory write-backs and %0d unhandled items.",
                 mem_writes, unhandled);
        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/cpualu_pkg.sv
hw/rtl/cpu_alu_register_execute.sv
bench/tb_top.sv
